@@ rtl/tcw_pkg.sv @@
// Shared types and character codes for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

package tcw_pkg;

    localparam logic [7:0] CLEAR_CODE = 8'd12;
    localparam logic [7:0] LF_CODE    = 8'd10;
    localparam logic [7:0] CR_CODE    = 8'd13;
    localparam logic [7:0] BLANK_CODE = 8'd32;

    typedef struct packed {
        logic capture;
        logic exec;
        logic rd_issue;
        logic sweep_wr;
        logic out_load;
    } cmd_t;

    typedef struct packed {
        logic is_read;
        logic need_sweep;
        logic sweep_last;
    } status_t;

endpackage

`default_nettype wire

@@ rtl/tcw_ctrl.sv @@
// Controller state machine for the text console writer.
`timescale 1ns / 1ps
`default_nettype none

module tcw_ctrl (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire logic            in_valid,
    output logic                 in_ready,
    output logic                 out_valid,
    input  wire logic            out_ready,
    input  wire tcw_pkg::status_t status,
    output tcw_pkg::cmd_t        cmd
);

    typedef enum logic [5:0] {
        S_INIT  = 6'b000001,
        S_IDLE  = 6'b000010,
        S_EXEC  = 6'b000100,
        S_RADDR = 6'b001000,
        S_SWEEP = 6'b010000,
        S_DONE  = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_valid_reg;
    logic   out_valid_next;
    logic   out_free;

    assign out_free  = !out_valid_reg || out_ready;
    assign in_ready  = (state_reg == S_IDLE);
    assign out_valid = out_valid_reg;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        case (state_reg)
            S_INIT:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.capture = 1'b1;
                    state_next  = S_EXEC;
                end
            end
            S_EXEC:
            begin
                cmd.exec = 1'b1;
                if (status.is_read)
                begin
                    state_next = S_RADDR;
                end
                else if (status.need_sweep)
                begin
                    state_next = S_SWEEP;
                end
                else
                begin
                    state_next = S_DONE;
                end
            end
            S_RADDR:
            begin
                cmd.rd_issue = 1'b1;
                state_next   = S_DONE;
            end
            S_SWEEP:
            begin
                cmd.sweep_wr = 1'b1;
                if (status.sweep_last)
                begin
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (out_free)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_INIT;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.out_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

`default_nettype wire

@@ rtl/tcw_datapath.sv @@
// Datapath for the text console writer: cursor, row ring bases and screen store.
`timescale 1ns / 1ps
`default_nettype none

module tcw_datapath #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 60
) (
    input  wire logic            clk,
    input  wire logic            rst_n,
    input  wire tcw_pkg::cmd_t   cmd,
    output tcw_pkg::status_t     status,
    input  wire logic            kind,
    input  wire logic [7:0]      char_code,
    input  wire logic [5:0]      cell_row,
    input  wire logic [6:0]      cell_col,
    output logic [5:0]           cursor_row,
    output logic [6:0]           cursor_col,
    output logic [7:0]           cell_data
);

    localparam int CELLS = COLUMNS * ROWS;
    localparam int AW    = $clog2(CELLS);
    localparam int SW    = $clog2(CELLS + 1);
    localparam int RW    = $clog2(ROWS);
    localparam int CW    = $clog2(COLUMNS);

    logic [7:0]    mem [CELLS];

    logic          kind_reg;
    logic [7:0]    code_reg;
    logic [5:0]    row_in_reg;
    logic [6:0]    col_in_reg;

    logic [RW-1:0] cur_row_reg, cur_row_next;
    logic [CW-1:0] cur_col_reg, cur_col_next;
    logic [AW-1:0] cur_base_reg, cur_base_next;
    logic [AW-1:0] top_base_reg, top_base_next;
    logic [AW-1:0] sweep_addr_reg, sweep_addr_next;
    logic [SW-1:0] sweep_left_reg, sweep_left_next;
    logic [AW-1:0] rd_off_reg, rd_off_next;
    logic          range_reg, range_next;
    logic [7:0]    rd_data_reg;

    logic          is_clear, is_nl, is_chr, do_nl, at_bottom, wraps;
    logic [CW:0]   col_inc;
    logic [AW:0]   cur_step, top_step, rd_sum;
    logic [AW-1:0] cur_adv, top_adv, rd_row_base;
    logic [AW-1:0] chr_addr, rd_addr, waddr;
    logic [7:0]    wdata;
    logic          we, re;
    logic [8:0]    row_wide, col_wide;

    assign is_clear  = !kind_reg && (code_reg == tcw_pkg::CLEAR_CODE);
    assign is_nl     = !kind_reg &&
                       ((code_reg == tcw_pkg::LF_CODE) || (code_reg == tcw_pkg::CR_CODE));
    assign is_chr    = !kind_reg && !is_clear && !is_nl;
    assign col_inc   = (CW + 1)'(cur_col_reg) + (CW + 1)'(1);
    assign wraps     = (col_inc == (CW + 1)'(COLUMNS));
    assign do_nl     = is_nl || (is_chr && wraps);
    assign at_bottom = (cur_row_reg == RW'(ROWS - 1));

    assign cur_step = (AW + 1)'(cur_base_reg) + (AW + 1)'(COLUMNS);
    assign top_step = (AW + 1)'(top_base_reg) + (AW + 1)'(COLUMNS);
    assign cur_adv  = (cur_step >= (AW + 1)'(CELLS)) ? AW'(cur_step - (AW + 1)'(CELLS))
                                                      : AW'(cur_step);
    assign top_adv  = (top_step >= (AW + 1)'(CELLS)) ? AW'(top_step - (AW + 1)'(CELLS))
                                                      : AW'(top_step);

    assign rd_sum      = (AW + 1)'(top_base_reg) + (AW + 1)'(rd_off_reg);
    assign rd_row_base = (rd_sum >= (AW + 1)'(CELLS)) ? AW'(rd_sum - (AW + 1)'(CELLS))
                                                       : AW'(rd_sum);
    assign rd_addr     = rd_row_base + AW'(col_in_reg);
    assign chr_addr    = cur_base_reg + AW'(cur_col_reg);

    assign status.is_read    = kind_reg;
    assign status.need_sweep = is_clear || (do_nl && at_bottom);
    assign status.sweep_last = (sweep_left_reg == SW'(1));

    assign we    = (cmd.exec && is_chr) || cmd.sweep_wr;
    assign waddr = cmd.sweep_wr ? sweep_addr_reg : chr_addr;
    assign wdata = cmd.sweep_wr ? tcw_pkg::BLANK_CODE : code_reg;
    assign re    = cmd.rd_issue && range_reg;

    assign row_wide = 9'(cur_row_reg);
    assign col_wide = 9'(cur_col_reg);

    always_comb
    begin
        cur_row_next    = cur_row_reg;
        cur_col_next    = cur_col_reg;
        cur_base_next   = cur_base_reg;
        top_base_next   = top_base_reg;
        sweep_addr_next = sweep_addr_reg;
        sweep_left_next = sweep_left_reg;
        rd_off_next     = rd_off_reg;
        range_next      = range_reg;
        if (cmd.exec)
        begin
            if (kind_reg)
            begin
                rd_off_next = AW'((AW + 1)'(row_in_reg) * (AW + 1)'(COLUMNS));
                range_next  = (9'(row_in_reg) < 9'(ROWS)) && (9'(col_in_reg) < 9'(COLUMNS));
            end
            else if (is_clear)
            begin
                cur_row_next    = '0;
                cur_col_next    = '0;
                cur_base_next   = '0;
                top_base_next   = '0;
                sweep_addr_next = '0;
                sweep_left_next = SW'(CELLS);
            end
            else
            begin
                if (is_chr)
                begin
                    cur_col_next = col_inc[CW-1:0];
                end
                if (do_nl)
                begin
                    cur_col_next = '0;
                    if (at_bottom)
                    begin
                        sweep_addr_next = top_base_reg;
                        sweep_left_next = SW'(COLUMNS);
                        top_base_next   = top_adv;
                        cur_base_next   = top_base_reg;
                    end
                    else
                    begin
                        cur_row_next  = cur_row_reg + RW'(1);
                        cur_base_next = cur_adv;
                    end
                end
            end
        end
        if (cmd.sweep_wr)
        begin
            sweep_addr_next = sweep_addr_reg + AW'(1);
            sweep_left_next = sweep_left_reg - SW'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cur_row_reg    <= '0;
            cur_col_reg    <= '0;
            cur_base_reg   <= '0;
            top_base_reg   <= '0;
            sweep_addr_reg <= '0;
            sweep_left_reg <= SW'(CELLS);
        end
        else
        begin
            cur_row_reg    <= cur_row_next;
            cur_col_reg    <= cur_col_next;
            cur_base_reg   <= cur_base_next;
            top_base_reg   <= top_base_next;
            sweep_addr_reg <= sweep_addr_next;
            sweep_left_reg <= sweep_left_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            kind_reg   <= kind;
            code_reg   <= char_code;
            row_in_reg <= cell_row;
            col_in_reg <= cell_col;
        end
        rd_off_reg <= rd_off_next;
        range_reg  <= range_next;
        if (cmd.out_load)
        begin
            cursor_row <= row_wide[5:0];
            cursor_col <= col_wide[6:0];
            cell_data  <= (kind_reg && range_reg) ? rd_data_reg : 8'd0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rd_data_reg <= mem[rd_addr];
        end
    end

endmodule

`default_nettype wire

@@ rtl/text_console_writer.sv @@
// Top level of the text console writer: controller plus datapath.
// Steps: capture, exec, then done for a put; a read-address step for a read; a blanking sweep of
// COLUMNS cells for a new line that scrolls, ROWS*COLUMNS for a clear (one cell per cycle).
// Throughput: one item at a time; the next beat is taken only after the last result is loaded,
// later while the previous result still waits to be taken.
// Reset: cursor homes and a blanking pass over all ROWS*COLUMNS cells runs first.
`timescale 1ns / 1ps
`default_nettype none

module text_console_writer #(
    parameter int COLUMNS = 80,
    parameter int ROWS    = 60
) (
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       in_valid,
    output logic            in_ready,
    input  wire logic       kind,
    input  wire logic [7:0] char_code,
    input  wire logic [5:0] cell_row,
    input  wire logic [6:0] cell_col,
    output logic            out_valid,
    input  wire logic       out_ready,
    output logic [5:0]      cursor_row,
    output logic [6:0]      cursor_col,
    output logic [7:0]      cell_data
);

    tcw_pkg::cmd_t    cmd;
    tcw_pkg::status_t status;

    tcw_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .status    (status),
        .cmd       (cmd)
    );

    tcw_datapath #(
        .COLUMNS (COLUMNS),
        .ROWS    (ROWS)
    ) u_datapath (
        .clk        (clk),
        .rst_n      (rst_n),
        .cmd        (cmd),
        .status     (status),
        .kind       (kind),
        .char_code  (char_code),
        .cell_row   (cell_row),
        .cell_col   (cell_col),
        .cursor_row (cursor_row),
        .cursor_col (cursor_col),
        .cell_data  (cell_data)
    );

endmodule

`default_nettype wire
